>>> src/imm_pkg.sv
// shared types and command codes for the integer matrix multiplier
`default_nettype none

package imm_pkg;

  localparam int unsigned IDX_W  = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SIDE   = 1 << IDX_W;
  localparam int unsigned DEPTH  = SIDE * SIDE;

  typedef logic [1:0]          cmd_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [2*IDX_W-1:0]  addr_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic signed [WORD_W-1:0] sword_t;

  localparam cmd_t CMD_LOAD_LEFT  = 2'd0;
  localparam cmd_t CMD_LOAD_RIGHT = 2'd1;
  localparam cmd_t CMD_COMPUTE    = 2'd2;

endpackage

`default_nettype wire

>>> src/imm_if.sv
// valid/ready channel interfaces for commands and product elements
`default_nettype none

interface imm_in_if;
  import imm_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  idx_t   row_index;
  idx_t   col_index;
  sword_t element_value;

  modport source (output valid, output command, output row_index, output col_index,
                  output element_value, input ready);
  modport sink   (input valid, input command, input row_index, input col_index,
                  input element_value, output ready);
endinterface

interface imm_out_if;
  import imm_pkg::*;

  logic   valid;
  logic   ready;
  idx_t   out_row;
  idx_t   out_col;
  sword_t product_sum;
  logic   last_element;

  modport source (output valid, output out_row, output out_col, output product_sum,
                  output last_element, input ready);
  modport sink   (input valid, input out_row, input out_col, input product_sum,
                  input last_element, output ready);
endinterface

`default_nettype wire

>>> src/imm_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none

module imm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/int32_matrix_multiply.sv
// a load command is taken while idle; a compute command runs until the last element
// of C is taken, and no command is taken meanwhile
// throughput: one multiply-accumulate per cycle through the single 32x32 multiplier,
// fed by one read port on each matrix store, paused while each element drains and emits
// reset: synchronous active-low rst_n returns the sequencer to idle and drops out valid;
// matrix stores are not cleared and must be loaded before a compute
`default_nettype none

module int32_matrix_multiply #(
  parameter int unsigned LEFT_ROWS  = 8,
  parameter int unsigned INNER_LEN  = 8,
  parameter int unsigned RIGHT_COLS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  imm_in_if.sink     in_if,
  imm_out_if.source  out_if
);
  import imm_pkg::*;

  // dimensions above the store side act as the full side
  localparam int unsigned ROWS  = (LEFT_ROWS  > SIDE) ? SIDE : LEFT_ROWS;
  localparam int unsigned INNER = (INNER_LEN  > SIDE) ? SIDE : INNER_LEN;
  localparam int unsigned COLS  = (RIGHT_COLS > SIDE) ? SIDE : RIGHT_COLS;
  localparam logic        NO_RUN   = (ROWS == 0) || (COLS == 0);
  localparam logic        NO_TERMS = (INNER == 0);

  localparam idx_t LAST_ROW = IDX_W'((ROWS  == 0) ? 0 : ROWS  - 1);
  localparam idx_t LAST_K   = IDX_W'((INNER == 0) ? 0 : INNER - 1);
  localparam idx_t LAST_COL = IDX_W'((COLS  == 0) ? 0 : COLS  - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  idx_t   i_r, i_nxt;
  idx_t   j_r, j_nxt;
  idx_t   k_r, k_nxt;
  logic   rd_vld_r, rd_vld_nxt;
  logic   mul_vld_r, mul_vld_nxt;
  word_t  prod_r, prod_nxt;
  word_t  acc_r, acc_nxt;
  logic   out_valid_r, out_valid_nxt;
  idx_t   out_row_r, out_row_nxt;
  idx_t   out_col_r, out_col_nxt;
  word_t  out_sum_r, out_sum_nxt;
  logic   out_last_r, out_last_nxt;

  logic   in_xfer;
  logic   out_xfer;
  logic   wr_left;
  logic   wr_right;
  logic   rd_en;
  addr_t  wr_addr;
  addr_t  left_rd_addr;
  addr_t  right_rd_addr;
  word_t  left_rd_data;
  word_t  right_rd_data;
  logic   at_last;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_xfer    = out_valid_r && out_if.ready;

  assign wr_addr  = {in_if.row_index, in_if.col_index};
  assign wr_left  = in_xfer && (in_if.command == CMD_LOAD_LEFT);
  assign wr_right = in_xfer && (in_if.command == CMD_LOAD_RIGHT);

  assign rd_en         = (state_r == S_ISSUE);
  assign left_rd_addr  = {i_r, k_r};
  assign right_rd_addr = {k_r, j_r};

  assign at_last = (i_r == LAST_ROW) && (j_r == LAST_COL);

  imm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_left_ram (
    .clk     (clk),
    .wr_en   (wr_left),
    .wr_addr (wr_addr),
    .wr_data (word_t'(in_if.element_value)),
    .rd_en   (rd_en),
    .rd_addr (left_rd_addr),
    .rd_data (left_rd_data)
  );

  imm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_right_ram (
    .clk     (clk),
    .wr_en   (wr_right),
    .wr_addr (wr_addr),
    .wr_data (word_t'(in_if.element_value)),
    .rd_en   (rd_en),
    .rd_addr (right_rd_addr),
    .rd_data (right_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    rd_vld_nxt    = 1'b0;
    mul_vld_nxt   = rd_vld_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_sum_nxt   = out_sum_r;
    out_last_nxt  = out_last_r;

    // low 32 bits of the product are the same for signed and unsigned operands
    if (rd_vld_r) begin
      prod_nxt = left_rd_data * right_rd_data;
    end
    if (mul_vld_r) begin
      acc_nxt = acc_r + prod_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_if.command == CMD_COMPUTE) && !NO_RUN) begin
          i_nxt   = '0;
          j_nxt   = '0;
          k_nxt   = '0;
          acc_nxt = '0;
          if (NO_TERMS) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        rd_vld_nxt = 1'b1;
        if (k_r == LAST_K) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !mul_vld_r) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = i_r;
          out_col_nxt   = j_r;
          out_sum_nxt   = acc_r;
          out_last_nxt  = at_last;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          k_nxt         = '0;
          acc_nxt       = '0;
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            if (NO_TERMS) begin
              state_nxt = S_DRAIN;
            end else begin
              state_nxt = S_ISSUE;
            end
            if (j_r == LAST_COL) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      mul_vld_r   <= mul_vld_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      prod_r      <= prod_nxt;
      acc_r       <= acc_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_sum_r   <= out_sum_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.out_row      = out_row_r;
  assign out_if.out_col      = out_col_r;
  assign out_if.product_sum  = sword_t'(out_sum_r);
  assign out_if.last_element = out_last_r;

`ifndef NO_ASSERTIONS
  // a result is only presented from the emit state
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT))
    else $error("result valid outside emit state");

  // no command is taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_if.ready)
    else $error("command ready while result pending");

  // read data always moves into the multiply stage
  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |=> mul_vld_r)
    else $error("multiply stage lost read data");

  // accumulation is complete before a result is shown
  a_pipe_empty_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (!rd_vld_r && !mul_vld_r))
    else $error("result shown with products in flight");

  // run ends only after the flagged last element transfers
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_r) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after last element");
`endif

endmodule

`default_nettype wire

>>> tb/tb_int32_matrix_multiply.sv
// self-checking testbench for int32_matrix_multiply: random loads and computes against a predictor
`timescale 1ns / 1ps

module tb_int32_matrix_multiply;
  import imm_pkg::*;

  localparam int unsigned LEFT_ROWS  = 8;
  localparam int unsigned INNER_LEN  = 8;
  localparam int unsigned RIGHT_COLS = 8;
  localparam int unsigned QUIET_LIMIT = 4000;

  localparam cmd_t   CMD_UNUSED = 2'd3;
  localparam sword_t WORD_MIN   = 32'sh8000_0000;
  localparam sword_t WORD_MAX   = 32'sh7fff_ffff;

  typedef struct {
    cmd_t   command;
    idx_t   row;
    idx_t   col;
    sword_t value;
  } cmd_item_t;

  typedef struct {
    idx_t   row;
    idx_t   col;
    word_t  sum;
    logic   last;
  } product_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  imm_in_if  cmd_ch ();
  imm_out_if prod_ch ();

  int32_matrix_multiply #(
    .LEFT_ROWS  (LEFT_ROWS),
    .INNER_LEN  (INNER_LEN),
    .RIGHT_COLS (RIGHT_COLS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch.sink),
    .out_if (prod_ch.source)
  );

  cmd_item_t pending_cmds[$];
  product_t  expected_products[$];
  word_t     left_mat [DEPTH];
  word_t     right_mat[DEPTH];
  cmd_item_t on_bus;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // every element of the product, row-major, low 32 bits of each term
  function automatic void predict_product();
    product_t p;
    word_t    acc;
    for (int i = 0; i < LEFT_ROWS; i++) begin
      for (int j = 0; j < RIGHT_COLS; j++) begin
        acc = '0;
        for (int k = 0; k < INNER_LEN; k++) begin
          acc = acc + left_mat[i*SIDE + k] * right_mat[k*SIDE + j];
        end
        p.row  = idx_t'(i);
        p.col  = idx_t'(j);
        p.sum  = acc;
        p.last = (i == LEFT_ROWS - 1) && (j == RIGHT_COLS - 1);
        expected_products.push_back(p);
      end
    end
  endfunction

  function automatic void apply_command(input cmd_item_t c);
    case (c.command)
      CMD_LOAD_LEFT:  left_mat[{c.row, c.col}]  = word_t'(c.value);
      CMD_LOAD_RIGHT: right_mat[{c.row, c.col}] = word_t'(c.value);
      CMD_COMPUTE:    predict_product();
      default: ;
    endcase
  endfunction

  function automatic sword_t pick_element();
    case ($urandom_range(7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return 32'sd1;
      default: return sword_t'($urandom);
    endcase
  endfunction

  function automatic void queue_cmd(input cmd_t command, input idx_t row, input idx_t col,
                                    input sword_t value);
    cmd_item_t c;
    c.command = command;
    c.row     = row;
    c.col     = col;
    c.value   = value;
    pending_cmds.push_back(c);
  endfunction

  function automatic void queue_random_cmds(input int count);
    int   pick;
    cmd_t command;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 44)      command = CMD_LOAD_LEFT;
      else if (pick < 88) command = CMD_LOAD_RIGHT;
      else if (pick < 95) command = CMD_COMPUTE;
      else                command = CMD_UNUSED;
      queue_cmd(command, idx_t'($urandom), idx_t'($urandom), pick_element());
    end
  endfunction

  task automatic wait_until_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_products.size() != 0)
      @(negedge clk);
  endtask

  // command driver
  always @(posedge clk) begin : drive_cmds
    cmd_item_t nxt;
    logic      send;
    if (!rst_n) begin
      cmd_ch.valid         <= 1'b0;
      cmd_ch.command       <= CMD_UNUSED;
      cmd_ch.row_index     <= '0;
      cmd_ch.col_index     <= '0;
      cmd_ch.element_value <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_command(on_bus);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        send = pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (send) begin
          nxt = pending_cmds.pop_front();
          on_bus = nxt;
          cmd_ch.command       <= nxt.command;
          cmd_ch.row_index     <= nxt.row;
          cmd_ch.col_index     <= nxt.col;
          cmd_ch.element_value <= nxt.value;
        end
        cmd_ch.valid <= send;
      end
    end
  end

  // product monitor
  always @(posedge clk) begin : check_products
    product_t want;
    if (!rst_n) begin
      prod_ch.ready <= 1'b0;
    end else begin
      if (prod_ch.valid && prod_ch.ready) begin
        if (expected_products.size() == 0) begin
          report_mismatch($sformatf("unexpected element row %0d col %0d sum %0d",
                                    prod_ch.out_row, prod_ch.out_col, prod_ch.product_sum));
        end else begin
          want = expected_products.pop_front();
          if (prod_ch.out_row !== want.row)
            report_mismatch($sformatf("out_row %0d, want %0d", prod_ch.out_row, want.row));
          if (prod_ch.out_col !== want.col)
            report_mismatch($sformatf("out_col %0d, want %0d", prod_ch.out_col, want.col));
          if (word_t'(prod_ch.product_sum) !== want.sum)
            report_mismatch($sformatf("product_sum %0d at (%0d,%0d), want %0d",
                                      prod_ch.product_sum, want.row, want.col,
                                      sword_t'(want.sum)));
          if (prod_ch.last_element !== want.last)
            report_mismatch($sformatf("last_element %b at (%0d,%0d), want %b",
                                      prod_ch.last_element, want.row, want.col, want.last));
        end
      end
      prod_ch.ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (prod_ch.valid && prod_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_int32_matrix_multiply NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int a = 0; a < DEPTH; a++) begin
      left_mat[a]  = '0;
      right_mat[a] = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fill both stores so that no compute reads an unwritten entry
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        queue_cmd(CMD_LOAD_LEFT, idx_t'(r), idx_t'(c), pick_element());
        queue_cmd(CMD_LOAD_RIGHT, idx_t'(r), idx_t'(c), pick_element());
      end
    end

    // corners, extreme values, ignored fields, unused command
    queue_cmd(CMD_UNUSED, '1, '1, -32'sd1);
    queue_cmd(CMD_COMPUTE, '0, '0, 32'sd0);
    queue_cmd(CMD_LOAD_LEFT, 3'd0, 3'd0, WORD_MIN);
    queue_cmd(CMD_LOAD_RIGHT, 3'd0, 3'd0, WORD_MIN);
    queue_cmd(CMD_LOAD_LEFT, 3'd7, 3'd7, WORD_MAX);
    queue_cmd(CMD_LOAD_RIGHT, 3'd7, 3'd7, WORD_MAX);
    queue_cmd(CMD_LOAD_LEFT, 3'd0, 3'd7, -32'sd1);
    queue_cmd(CMD_LOAD_RIGHT, 3'd7, 3'd0, -32'sd1);
    queue_cmd(CMD_LOAD_LEFT, 3'd7, 3'd0, 32'sd1);
    queue_cmd(CMD_LOAD_RIGHT, 3'd0, 3'd7, 32'sd0);
    queue_cmd(CMD_LOAD_LEFT, 3'd3, 3'd4, 32'sh5555_5555);
    queue_cmd(CMD_LOAD_RIGHT, 3'd4, 3'd3, 32'shaaaa_aaaa);
    queue_cmd(CMD_COMPUTE, '1, '1, -32'sd1);
    queue_cmd(CMD_UNUSED, '0, '0, 32'sd0);
    queue_cmd(CMD_COMPUTE, 3'd5, 3'd2, WORD_MIN);
    queue_random_cmds(60);
    wait_until_drained();

    send_idle_pct = 70;
    recv_stall_pct = 0;
    queue_random_cmds(65);
    wait_until_drained();

    send_idle_pct = 0;
    recv_stall_pct = 70;
    queue_random_cmds(65);
    wait_until_drained();

    send_idle_pct = 35;
    recv_stall_pct = 35;
    queue_random_cmds(65);
    queue_cmd(CMD_COMPUTE, idx_t'($urandom), idx_t'($urandom), pick_element());
    wait_until_drained();

    repeat (INNER_LEN + 12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_int32_matrix_multiply OK");
    end else begin
      $display("tb_int32_matrix_multiply NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/imm_pkg.sv
src/imm_if.sv
src/imm_ram.sv
src/int32_matrix_multiply.sv
tb/tb_int32_matrix_multiply.sv
